>>> rtl/personalized_pagerank_engine_macros.svh
`ifndef PERSONALIZED_PAGERANK_ENGINE_MACROS_SVH
`define PERSONALIZED_PAGERANK_ENGINE_MACROS_SVH

// same-cycle implication
`define PPR_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppr_pkg.sv
package ppr_pkg;

    localparam int MaxVerticesDef = 1024;
    localparam int MaxEdgesDef    = 8192;
    localparam int RankBitsDef    = 32;

    localparam logic [2:0] CFG_SOURCE    = 3'd0;
    localparam logic [2:0] CFG_VCOUNT    = 3'd1;
    localparam logic [2:0] CFG_ECOUNT    = 3'd2;
    localparam logic [2:0] CFG_DAMPING   = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_LIMIT     = 3'd5;

    localparam logic [9:0]  RST_SOURCE    = 10'd0;
    localparam logic [10:0] RST_VCOUNT    = 11'd1024;
    localparam logic [13:0] RST_ECOUNT    = 14'd0;
    localparam logic [15:0] RST_DAMPING   = 16'd55706;
    localparam logic [31:0] RST_THRESHOLD = 32'd2147;
    localparam logic [7:0]  RST_LIMIT     = 8'd100;

    localparam logic [1:0] MODE_LOAD_OFFSET = 2'd0;
    localparam logic [1:0] MODE_LOAD_EDGE   = 2'd1;
    localparam logic [1:0] MODE_RUN         = 2'd2;
    localparam logic [1:0] MODE_QUERY       = 2'd3;

    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_ACCEPT    = 5'd1;
    localparam logic [4:0] OP_RUN_START = 5'd2;
    localparam logic [4:0] OP_INIT_CLR  = 5'd3;
    localparam logic [4:0] OP_NCLR      = 5'd4;
    localparam logic [4:0] OP_RD_OFF0   = 5'd5;
    localparam logic [4:0] OP_RD_OFF1   = 5'd6;
    localparam logic [4:0] OP_GOT_END   = 5'd7;
    localparam logic [4:0] OP_DANG      = 5'd8;
    localparam logic [4:0] OP_SKIP      = 5'd9;
    localparam logic [4:0] OP_DIV_START = 5'd10;
    localparam logic [4:0] OP_DIV_STEP  = 5'd11;
    localparam logic [4:0] OP_E_RD      = 5'd12;
    localparam logic [4:0] OP_E_T       = 5'd13;
    localparam logic [4:0] OP_E_WR      = 5'd14;
    localparam logic [4:0] OP_E_NEXT    = 5'd15;
    localparam logic [4:0] OP_U_RD      = 5'd16;
    localparam logic [4:0] OP_U_MUL     = 5'd17;
    localparam logic [4:0] OP_U_WR      = 5'd18;
    localparam logic [4:0] OP_ITER_END  = 5'd19;
    localparam logic [4:0] OP_EMIT_R    = 5'd20;
    localparam logic [4:0] OP_EMIT_Q    = 5'd21;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       vtx_last;
        logic       vc_zero;
        logic       has_edges;
        logic       rank_zero;
        logic       div_done;
        logic       tgt_ok;
        logic       edge_last;
        logic       conv_hit;
        logic       iter_last;
        logic       limit_zero;
        logic       out_free;
    } t_status;

endpackage

>>> rtl/ppr_controller.sv
module ppr_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ppr_pkg::t_status i_status,
    output ppr_pkg::t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_QWAIT = 5'd1;
    localparam logic [4:0] S_RSTRT = 5'd2;
    localparam logic [4:0] S_INIT  = 5'd3;
    localparam logic [4:0] S_NCLR  = 5'd4;
    localparam logic [4:0] S_OFF0  = 5'd5;
    localparam logic [4:0] S_OFF1  = 5'd6;
    localparam logic [4:0] S_GEND  = 5'd7;
    localparam logic [4:0] S_DANG  = 5'd8;
    localparam logic [4:0] S_SKIP  = 5'd9;
    localparam logic [4:0] S_DIVS  = 5'd10;
    localparam logic [4:0] S_DIVR  = 5'd11;
    localparam logic [4:0] S_ERD   = 5'd12;
    localparam logic [4:0] S_ET    = 5'd13;
    localparam logic [4:0] S_EWR   = 5'd14;
    localparam logic [4:0] S_ENXT  = 5'd15;
    localparam logic [4:0] S_URD   = 5'd16;
    localparam logic [4:0] S_UMUL  = 5'd17;
    localparam logic [4:0] S_UWR   = 5'd18;
    localparam logic [4:0] S_IEND  = 5'd19;
    localparam logic [4:0] S_REMIT = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = ppr_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ppr_pkg::OP_ACCEPT;
                    case (i_status.in_mode)
                        ppr_pkg::MODE_RUN:   n_state = S_RSTRT;
                        ppr_pkg::MODE_QUERY: n_state = S_QWAIT;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_QWAIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = ppr_pkg::OP_EMIT_Q;
                    n_state  = S_IDLE;
                end
            end
            S_RSTRT: begin
                o_cmd.op = ppr_pkg::OP_RUN_START;
                n_state  = S_INIT;
            end
            S_INIT: begin
                o_cmd.op = ppr_pkg::OP_INIT_CLR;
                if (i_status.vtx_last) begin
                    n_state = i_status.limit_zero ? S_REMIT : S_NCLR;
                end
            end
            S_NCLR: begin
                o_cmd.op = ppr_pkg::OP_NCLR;
                if (i_status.vtx_last) begin
                    n_state = i_status.vc_zero ? S_IEND : S_OFF0;
                end
            end
            S_OFF0: begin
                o_cmd.op = ppr_pkg::OP_RD_OFF0;
                n_state  = S_OFF1;
            end
            S_OFF1: begin
                o_cmd.op = ppr_pkg::OP_RD_OFF1;
                n_state  = S_GEND;
            end
            S_GEND: begin
                o_cmd.op = ppr_pkg::OP_GOT_END;
                if (!i_status.has_edges) begin
                    n_state = S_DANG;
                end else if (i_status.rank_zero) begin
                    n_state = S_SKIP;
                end else begin
                    n_state = S_DIVS;
                end
            end
            S_DANG, S_SKIP: begin
                o_cmd.op = (r_state == S_DANG) ? ppr_pkg::OP_DANG : ppr_pkg::OP_SKIP;
                n_state  = i_status.vtx_last ? S_URD : S_OFF0;
            end
            S_DIVS: begin
                o_cmd.op = ppr_pkg::OP_DIV_START;
                n_state  = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.op = ppr_pkg::OP_DIV_STEP;
                if (i_status.div_done) begin
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.op = ppr_pkg::OP_E_RD;
                n_state  = S_ET;
            end
            S_ET: begin
                o_cmd.op = ppr_pkg::OP_E_T;
                n_state  = i_status.tgt_ok ? S_EWR : S_ENXT;
            end
            S_EWR: begin
                o_cmd.op = ppr_pkg::OP_E_WR;
                n_state  = S_ENXT;
            end
            S_ENXT: begin
                o_cmd.op = ppr_pkg::OP_E_NEXT;
                if (!i_status.edge_last) begin
                    n_state = S_ERD;
                end else begin
                    n_state = i_status.vtx_last ? S_URD : S_OFF0;
                end
            end
            S_URD: begin
                o_cmd.op = ppr_pkg::OP_U_RD;
                n_state  = S_UMUL;
            end
            S_UMUL: begin
                o_cmd.op = ppr_pkg::OP_U_MUL;
                n_state  = S_UWR;
            end
            S_UWR: begin
                o_cmd.op = ppr_pkg::OP_U_WR;
                n_state  = i_status.vtx_last ? S_IEND : S_URD;
            end
            S_IEND: begin
                o_cmd.op = ppr_pkg::OP_ITER_END;
                n_state  = (i_status.conv_hit || i_status.iter_last) ? S_REMIT : S_NCLR;
            end
            S_REMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = ppr_pkg::OP_EMIT_R;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/ppr_datapath.sv
`include "personalized_pagerank_engine_macros.svh"

module ppr_datapath #(
    parameter int MAX_VERTICES = ppr_pkg::MaxVerticesDef,
    parameter int MAX_EDGES    = ppr_pkg::MaxEdgesDef,
    parameter int RANK_BITS    = ppr_pkg::RankBitsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppr_pkg::t_cmd    i_cmd,
    output ppr_pkg::t_status o_status,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic [1:0]       i_mode,
    input  logic [12:0]      i_index,
    input  logic [13:0]      i_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_report_kind,
    output logic [31:0]      o_rank_value,
    output logic             o_rank_valid,
    output logic [7:0]       o_iterations_done,
    output logic             o_converged_flag
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CW  = (RANK_BITS > 32) ? RANK_BITS : 32;
    localparam int DCW = $clog2(RANK_BITS + 1);
    localparam int PW  = RANK_BITS + 16;

    localparam logic [RANK_BITS-1:0] RankOne = {1'b1, {(RANK_BITS-1){1'b0}}};

    function automatic logic [ECW-1:0] clamp_edge(input logic [13:0] x);
        logic [31:0] w;
        w = {18'd0, x};
        if (w > 32'(MAX_EDGES)) begin
            w = 32'(MAX_EDGES);
        end
        return w[ECW-1:0];
    endfunction

    function automatic logic [RANK_BITS-1:0] sat_add(input logic [RANK_BITS-1:0] a,
                                                     input logic [RANK_BITS-1:0] b);
        logic [RANK_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RANK_BITS] ? {RANK_BITS{1'b1}} : s[RANK_BITS-1:0];
    endfunction

    // config registers
    logic [9:0]  r_src;
    logic [10:0] r_vcount;
    logic [13:0] r_ecount;
    logic [15:0] r_damp;
    logic [31:0] r_thr;
    logic [7:0]  r_limit;

    // memories and registered read data
    logic [13:0]          r_off_mem  [MAX_VERTICES];
    logic [13:0]          r_edge_mem [MAX_EDGES];
    logic [RANK_BITS-1:0] r_rank_mem [MAX_VERTICES];
    logic [RANK_BITS-1:0] r_next_mem [MAX_VERTICES];
    logic [13:0]          r_off_q;
    logic [13:0]          r_edge_q;
    logic [RANK_BITS-1:0] r_rank_q;
    logic [RANK_BITS-1:0] r_next_q;

    // run state
    logic [VCW-1:0]       r_vi;
    logic [ECW-1:0]       r_ej;
    logic [ECW-1:0]       r_start;
    logic [ECW-1:0]       r_end;
    logic [VAW-1:0]       r_t;
    logic [RANK_BITS-1:0] r_rank_i;
    logic [RANK_BITS-1:0] r_dang;
    logic [RANK_BITS-1:0] r_maxd;
    logic [PW-1:0]        r_prod;
    logic [7:0]           r_iter;
    logic                 r_conv;
    logic                 r_have;
    logic                 r_q_ok;

    // divider
    logic [ECW:0]         r_div_rem;
    logic [RANK_BITS-1:0] r_quot;
    logic [ECW-1:0]       r_div;
    logic [DCW-1:0]       r_div_cnt;

    // output register
    logic                 r_out_valid;
    logic                 r_kind;
    logic [31:0]          r_value;
    logic                 r_valid;
    logic [7:0]           r_iters_o;
    logic                 r_conv_o;

    logic [31:0]          vc32;
    logic [VCW-1:0]       vc;
    logic [ECW-1:0]       ec;
    logic                 src_ok;
    logic [31:0]          vi32;
    logic [31:0]          idx32;
    logic [31:0]          t32;
    logic                 is_src;
    logic                 vtx_last;
    logic [VCW-1:0]       vi_p1;
    logic [VCW-1:0]       vi_adv;
    logic [ECW-1:0]       end_next;
    logic [ECW:0]         rem_sh;
    logic                 div_ge;
    logic [RANK_BITS+15:0] rest_wide;
    logic [RANK_BITS-1:0] restart;
    logic [RANK_BITS-1:0] s_val;
    logic [RANK_BITS-1:0] v_raw;
    logic [RANK_BITS-1:0] v_val;
    logic [RANK_BITS-1:0] d_val;
    logic [RANK_BITS-1:0] rq;
    logic [CW-1:0]        rq_w;
    logic                 out_free;
    logic [4:0]           op;

    assign op     = i_cmd.op;
    assign vc32   = ({21'd0, r_vcount} > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                           : {21'd0, r_vcount};
    assign vc     = vc32[VCW-1:0];
    assign ec     = clamp_edge(r_ecount);
    assign src_ok = ({22'd0, r_src} < vc32);
    assign vi32   = {{(32-VCW){1'b0}}, r_vi};
    assign idx32  = {19'd0, i_index};
    assign t32    = {18'd0, r_edge_q};
    assign is_src = src_ok && (vi32 == {22'd0, r_src});
    assign vtx_last = ((vi32 + 32'd1) >= vc32);
    assign vi_p1  = r_vi + VCW'(1);
    assign vi_adv = vtx_last ? '0 : vi_p1;
    assign end_next = vtx_last ? ec : clamp_edge(r_off_q);

    assign rem_sh = {r_div_rem[ECW-1:0], r_quot[RANK_BITS-1]};
    assign div_ge = (rem_sh >= {1'b0, r_div});

    assign rest_wide = {(17'h10000 - {1'b0, r_damp}), {(RANK_BITS-1){1'b0}}};
    assign restart   = rest_wide[RANK_BITS+15:16];

    assign s_val = is_src ? sat_add(r_next_q, r_dang) : r_next_q;
    assign v_raw = r_prod[RANK_BITS+15:16];
    assign v_val = is_src ? sat_add(v_raw, restart) : v_raw;
    assign d_val = (v_val > r_rank_i) ? (v_val - r_rank_i) : (r_rank_i - v_val);

    assign rq   = (r_q_ok && r_have) ? r_rank_q : '0;
    assign rq_w = CW'(rq);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.in_mode    = i_mode;
        o_status.vtx_last   = vtx_last;
        o_status.vc_zero    = (vc32 == 32'd0);
        o_status.has_edges  = (end_next > r_start);
        o_status.rank_zero  = (r_rank_i == '0);
        o_status.div_done   = (r_div_cnt == DCW'(1));
        o_status.tgt_ok     = (t32 < vc32);
        o_status.edge_last  = (({1'b0, r_ej} + 1'b1) == {1'b0, r_end});
        o_status.conv_hit   = (CW'(r_maxd) < CW'(r_thr));
        o_status.iter_last  = (({1'b0, r_iter} + 9'd1) >= {1'b0, r_limit});
        o_status.limit_zero = (r_limit == 8'd0);
        o_status.out_free   = out_free;
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= ppr_pkg::RST_SOURCE;
            r_vcount <= ppr_pkg::RST_VCOUNT;
            r_ecount <= ppr_pkg::RST_ECOUNT;
            r_damp   <= ppr_pkg::RST_DAMPING;
            r_thr    <= ppr_pkg::RST_THRESHOLD;
            r_limit  <= ppr_pkg::RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppr_pkg::CFG_SOURCE:    r_src    <= i_cfg_data[9:0];
                ppr_pkg::CFG_VCOUNT:    r_vcount <= i_cfg_data[10:0];
                ppr_pkg::CFG_ECOUNT:    r_ecount <= i_cfg_data[13:0];
                ppr_pkg::CFG_DAMPING:   r_damp   <= i_cfg_data[15:0];
                ppr_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data;
                ppr_pkg::CFG_LIMIT:     r_limit  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // offset store
    always_ff @(posedge i_clk) begin
        if (op == ppr_pkg::OP_ACCEPT && i_mode == ppr_pkg::MODE_LOAD_OFFSET &&
            idx32 < 32'(MAX_VERTICES)) begin
            r_off_mem[idx32[VAW-1:0]] <= i_value;
        end
        if (op == ppr_pkg::OP_RD_OFF0) begin
            r_off_q <= r_off_mem[r_vi[VAW-1:0]];
        end else if (op == ppr_pkg::OP_RD_OFF1) begin
            r_off_q <= r_off_mem[vi_p1[VAW-1:0]];
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (op == ppr_pkg::OP_ACCEPT && i_mode == ppr_pkg::MODE_LOAD_EDGE &&
            idx32 < 32'(MAX_EDGES)) begin
            r_edge_mem[idx32[EAW-1:0]] <= i_value;
        end
        if (op == ppr_pkg::OP_E_RD) begin
            r_edge_q <= r_edge_mem[r_ej[EAW-1:0]];
        end
    end

    // rank store
    always_ff @(posedge i_clk) begin
        if (op == ppr_pkg::OP_INIT_CLR) begin
            r_rank_mem[r_vi[VAW-1:0]] <= is_src ? RankOne : '0;
        end else if (op == ppr_pkg::OP_U_WR) begin
            r_rank_mem[r_vi[VAW-1:0]] <= v_val;
        end
        if (op == ppr_pkg::OP_ACCEPT && i_mode == ppr_pkg::MODE_QUERY) begin
            r_rank_q <= r_rank_mem[idx32[VAW-1:0]];
        end else if (op == ppr_pkg::OP_RD_OFF0 || op == ppr_pkg::OP_U_RD) begin
            r_rank_q <= r_rank_mem[r_vi[VAW-1:0]];
        end
    end

    // next rank store
    always_ff @(posedge i_clk) begin
        if (op == ppr_pkg::OP_NCLR) begin
            r_next_mem[r_vi[VAW-1:0]] <= '0;
        end else if (op == ppr_pkg::OP_E_WR) begin
            r_next_mem[r_t] <= sat_add(r_next_q, r_quot);
        end
        if (op == ppr_pkg::OP_E_T) begin
            r_next_q <= r_next_mem[t32[VAW-1:0]];
        end else if (op == ppr_pkg::OP_U_RD) begin
            r_next_q <= r_next_mem[r_vi[VAW-1:0]];
        end
    end

    // run datapath
    always_ff @(posedge i_clk) begin
        case (op)
            ppr_pkg::OP_ACCEPT: begin
                r_q_ok <= (idx32 < vc32);
            end
            ppr_pkg::OP_RUN_START: begin
                r_vi   <= '0;
                r_dang <= '0;
                r_maxd <= '0;
            end
            ppr_pkg::OP_INIT_CLR, ppr_pkg::OP_NCLR, ppr_pkg::OP_SKIP, ppr_pkg::OP_U_WR: begin
                r_vi <= vi_adv;
                if (op == ppr_pkg::OP_U_WR && d_val > r_maxd) begin
                    r_maxd <= d_val;
                end
            end
            ppr_pkg::OP_RD_OFF1: begin
                r_start  <= clamp_edge(r_off_q);
                r_rank_i <= r_rank_q;
            end
            ppr_pkg::OP_GOT_END: begin
                r_end <= end_next;
            end
            ppr_pkg::OP_DANG: begin
                r_dang <= sat_add(r_dang, r_rank_i);
                r_vi   <= vi_adv;
            end
            ppr_pkg::OP_DIV_START: begin
                r_div_rem <= '0;
                r_quot    <= r_rank_i;
                r_div     <= r_end - r_start;
                r_div_cnt <= DCW'(RANK_BITS);
                r_ej      <= r_start;
            end
            ppr_pkg::OP_DIV_STEP: begin
                r_div_rem <= div_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quot    <= {r_quot[RANK_BITS-2:0], div_ge};
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
            ppr_pkg::OP_E_T: begin
                r_t <= t32[VAW-1:0];
            end
            ppr_pkg::OP_E_NEXT: begin
                r_ej <= r_ej + ECW'(1);
                if (o_status.edge_last) begin
                    r_vi <= vi_adv;
                end
            end
            ppr_pkg::OP_U_MUL: begin
                r_prod   <= PW'(r_damp) * PW'(s_val);
                r_rank_i <= r_rank_q;
            end
            ppr_pkg::OP_ITER_END: begin
                r_dang <= '0;
                r_maxd <= '0;
                r_vi   <= '0;
            end
            default: ;
        endcase
    end

    // run status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= 8'd0;
            r_conv <= 1'b0;
            r_have <= 1'b0;
        end else if (op == ppr_pkg::OP_RUN_START) begin
            r_iter <= 8'd0;
            r_conv <= 1'b0;
            r_have <= 1'b1;
        end else if (op == ppr_pkg::OP_ITER_END) begin
            r_iter <= r_iter + 8'd1;
            r_conv <= o_status.conv_hit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (op == ppr_pkg::OP_EMIT_R || op == ppr_pkg::OP_EMIT_Q) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == ppr_pkg::OP_EMIT_R) begin
            r_kind    <= 1'b1;
            r_value   <= 32'd0;
            r_valid   <= 1'b0;
            r_iters_o <= r_iter;
            r_conv_o  <= r_conv;
        end else if (op == ppr_pkg::OP_EMIT_Q) begin
            r_kind    <= 1'b0;
            r_value   <= rq_w[31:0];
            r_valid   <= r_q_ok;
            r_iters_o <= r_iter;
            r_conv_o  <= r_conv;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_report_kind     = r_kind;
    assign o_rank_value      = r_value;
    assign o_rank_valid      = r_valid;
    assign o_iterations_done = r_iters_o;
    assign o_converged_flag  = r_conv_o;

    `PPR_ASSERT_HOLDS(a_emit_slot, i_clk, i_rst_n, (op == ppr_pkg::OP_EMIT_R || op == ppr_pkg::OP_EMIT_Q), out_free, "result loaded over a waiting result")
    `PPR_ASSERT_HOLDS(a_div_count, i_clk, i_rst_n, op == ppr_pkg::OP_DIV_STEP, r_div_cnt != '0, "divider stepped past its last bit")
    `PPR_ASSERT_HOLDS(a_edge_range, i_clk, i_rst_n, op == ppr_pkg::OP_E_RD, r_ej < r_end, "edge read beyond end of list")
    `PPR_ASSERT_HOLDS(a_tgt_range, i_clk, i_rst_n, op == ppr_pkg::OP_E_WR, {{(32-VAW){1'b0}}, r_t} < vc32, "share written to vertex outside graph")
    `PPR_ASSERT_NEXT(a_iter_inc, i_clk, i_rst_n, op == ppr_pkg::OP_ITER_END && r_iter < r_limit, r_iter == $past(r_iter) + 8'd1, "iteration count did not advance")

endmodule

>>> rtl/personalized_pagerank_engine.sv
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_mode, i_index, i_value
// result    out        o_out_valid / i_out_stall   o_report_kind, o_rank_value, o_rank_valid,
//                                                  o_iterations_done, o_converged_flag
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// load items are written as they are accepted and do not stall the input; a query item stalls the input
// until the result register is free; a run first sets up the rank store with the source as the only ranked
// vertex, then each iteration clears the next-rank store, reads the offsets of each vertex, runs the divider
// for each vertex with rank and edges, reads its edges with a next-rank read-modify-write, and updates each rank
// the single-port rank, next-rank, offset and edge memories set the per-edge and per-vertex cost
// reset is synchronous, active low; rank store reads as zero until the first run
// the input is stalled while an item is at work; a stalled result holds in its register
module personalized_pagerank_engine #(
    parameter int MAX_VERTICES = ppr_pkg::MaxVerticesDef,
    parameter int MAX_EDGES    = ppr_pkg::MaxEdgesDef,
    parameter int RANK_BITS    = ppr_pkg::RankBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_index,
    input  logic [13:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_report_kind,
    output logic [31:0] o_rank_value,
    output logic        o_rank_valid,
    output logic [7:0]  o_iterations_done,
    output logic        o_converged_flag
);

    ppr_pkg::t_cmd    cmd;
    ppr_pkg::t_status status;

    ppr_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppr_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .RANK_BITS    (RANK_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_index           (i_index),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_report_kind     (o_report_kind),
        .o_rank_value      (o_rank_value),
        .o_rank_valid      (o_rank_valid),
        .o_iterations_done (o_iterations_done),
        .o_converged_flag  (o_converged_flag)
    );

endmodule
